// ----- hdl/ppad_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the point pair angle unit.
package ppad_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PRESCALE = 8;
	localparam int XY_W    = 28;
	localparam int Z_W     = 25;
	localparam int FRAC_W  = 16;
	localparam int A_W     = 23;
	localparam int Q_W     = 26;
	localparam int ANGLE_W = 10;

	localparam logic MODE_ATAN2  = 1'b0;
	localparam logic MODE_SCREEN = 1'b1;

	// atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
	localparam logic [A_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
		23'd234379,  23'd117304,  23'd58666,  23'd29335,
		23'd14668,   23'd7334,    23'd3667,   23'd1833,
		23'd917,     23'd458,     23'd229,    23'd115,
		23'd57,      23'd29,      23'd14,     23'd7,
		23'd4,       23'd2,       23'd1,      23'd0
	};

	localparam logic signed [Z_W-1:0] A_MIN_Q16 = 25'sd1;
	localparam logic signed [Z_W-1:0] A_MAX_Q16 = 25'sd5898239;
	localparam logic [Q_W-1:0] DEG180_Q16 = 26'd11796480;
	localparam logic [Q_W-1:0] DEG360_Q16 = 26'd23592960;

	localparam logic signed [ANGLE_W-1:0] ANG_0     = 10'sd0;
	localparam logic signed [ANGLE_W-1:0] ANG_90    = 10'sd90;
	localparam logic signed [ANGLE_W-1:0] ANG_NEG90 = -10'sd90;
	localparam logic signed [ANGLE_W-1:0] ANG_180   = 10'sd180;
	localparam logic signed [ANGLE_W-1:0] ANG_270   = 10'sd270;
	localparam logic signed [ANGLE_W-1:0] ANG_MIN   = -10'sd180;
	localparam logic signed [ANGLE_W-1:0] ANG_MAX   = 10'sd359;

	typedef struct packed {
		logic dx_neg;
		logic dy_neg;
		logic dx_zero;
		logic dy_zero;
	} ppad_flags_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		ppad_flags_t            flags;
	} ppad_stage_t;

endpackage

// ----- hdl/point_pair_angle_degrees_unit.sv -----
// Top level of the point pair angle unit: entry stage, CORDIC cell chain and result register.
// Gives the direction from (first_x, first_y) to (second_x, second_y) in whole degrees. With
// angle_mode 0 the result follows atan2, -179..180 truncated toward zero, and equal points give
// 0; with angle_mode 1 it is 0..359 in screen quadrants (y grows downward), truncated, and
// equal points give 90. The unit takes one request every clock while the output side is not
// stalling; a request passes through the entry stage register that forms differences and
// magnitudes, the register of each CORDIC rotation cell of the chain, and the result register
// after quadrant placement. The whole chain advances together, so a stalled result holds
// every request behind it and in_stall follows the output stall directly. Write angle_mode
// only while no request is in flight; its value applies at the result register.
module point_pair_angle_degrees_unit #(
	parameter int CORDIC_STAGES = ppad_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] first_x,
	input  logic signed [15:0] first_y,
	input  logic signed [15:0] second_x,
	input  logic signed [15:0] second_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [9:0]  angle_degrees
);
	import ppad_pkg::*;

	logic                      advance;
	logic                      angle_mode_q;
	logic                      chain_valid [CORDIC_STAGES+1];
	ppad_stage_t               chain_data  [CORDIC_STAGES+1];
	logic signed [ANGLE_W-1:0] angle_next;
	logic                      out_valid_q;
	logic signed [ANGLE_W-1:0] angle_q;

	// advance the whole chain whenever the result register is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;

	// mode register: hold until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_mode_q <= MODE_ATAN2;
		end else if (cfg_we) begin
			angle_mode_q <= cfg_wdata;
		end
	end

	ppad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (in_valid),
		.first_x   (first_x),
		.first_y   (first_y),
		.second_x  (second_x),
		.second_y  (second_y),
		.out_valid (chain_valid[0]),
		.out_data  (chain_data[0])
	);

	// one rotation cell per CORDIC iteration, each handing its vector to the next
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		ppad_cell #(
			.STAGE (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_valid  (chain_valid[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	ppad_finish u_finish (
		.angle_mode (angle_mode_q),
		.in_data    (chain_data[CORDIC_STAGES]),
		.angle      (angle_next)
	);

	// result register: parts the chain from the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain_valid[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			angle_q <= angle_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign angle_degrees = angle_q;

	// a request in the entry stage must not move while the chain is held
	a_front_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(chain_valid[0] && !advance) |=> $stable(chain_data[0]))
		else $error("entry stage changed while the chain was held");

	// x magnitude must be positive at the end of the rotation chain (catches width overflow);
	// equal points carry a null vector and are left out
	a_x_positive : assert property (@(posedge clk) disable iff (!arst_n)
		(chain_valid[CORDIC_STAGES] && !(chain_data[CORDIC_STAGES].flags.dx_zero &&
			chain_data[CORDIC_STAGES].flags.dy_zero)) |-> (chain_data[CORDIC_STAGES].x > 0))
		else $error("CORDIC x went non-positive");

	// every delivered angle lies within the union of both mode ranges
	a_angle_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_degrees >= ANG_MIN && angle_degrees <= ANG_MAX))
		else $error("angle out of range");

endmodule

// ----- hdl/ppad_front.sv -----
// Entry stage: coordinate differences, magnitudes, sign flags and CORDIC start vector.
module ppad_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          in_valid,
	input  logic signed [15:0]            first_x,
	input  logic signed [15:0]            first_y,
	input  logic signed [15:0]            second_x,
	input  logic signed [15:0]            second_y,
	output logic                          out_valid,
	output ppad_pkg::ppad_stage_t         out_data
);
	import ppad_pkg::*;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0]        ax;
	logic [DIFF_W-1:0]        ay;
	ppad_stage_t              start;
	logic                     valid_s1;
	ppad_stage_t              data_s1;

	assign dx = DIFF_W'(second_x) - DIFF_W'(first_x);
	assign dy = DIFF_W'(second_y) - DIFF_W'(first_y);
	assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

	always_comb begin
		start.x             = XY_W'({ax[COORD_W-1:0], PRESCALE'(0)});
		start.y             = XY_W'({ay[COORD_W-1:0], PRESCALE'(0)});
		start.z             = '0;
		start.flags.dx_neg  = dx[DIFF_W-1];
		start.flags.dy_neg  = dy[DIFF_W-1];
		start.flags.dx_zero = (dx == '0);
		start.flags.dy_zero = (dy == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= start;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- hdl/ppad_cell.sv -----
// One vectoring CORDIC rotation cell with its own pipeline register.
module ppad_cell #(
	parameter int STAGE = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  in_valid,
	input  ppad_pkg::ppad_stage_t in_data,
	output logic                  out_valid,
	output ppad_pkg::ppad_stage_t out_data
);
	import ppad_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_DEG_Q16[STAGE]);

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	ppad_stage_t            next;
	logic                   valid_q;
	ppad_stage_t            data_q;

	assign xs = in_data.x >>> STAGE;
	assign ys = in_data.y >>> STAGE;

	// rotate towards the x axis, steering on the sign of y
	always_comb begin
		next = in_data;
		if (!in_data.y[XY_W-1]) begin
			next.x = in_data.x + ys;
			next.y = in_data.y - xs;
			next.z = in_data.z + ATAN_STEP;
		end else begin
			next.x = in_data.x - ys;
			next.y = in_data.y + xs;
			next.z = in_data.z - ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= next;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- hdl/ppad_finish.sv -----
// Quadrant placement, special cases and truncation to whole degrees.
module ppad_finish (
	input  logic                          angle_mode,
	input  ppad_pkg::ppad_stage_t         in_data,
	output logic signed [9:0]             angle
);
	import ppad_pkg::*;

	logic [A_W-1:0]            a;
	logic [Q_W-1:0]            a_q;
	logic [Q_W-1:0]            mag_q;
	logic [Q_W-1:0]            full_q;
	logic signed [ANGLE_W-1:0] mag;
	ppad_flags_t               f;

	assign f = in_data.flags;

	// clamp to the open first quadrant
	always_comb begin
		if (in_data.z < A_MIN_Q16) begin
			a = A_W'(A_MIN_Q16);
		end else if (in_data.z > A_MAX_Q16) begin
			a = A_W'(A_MAX_Q16);
		end else begin
			a = in_data.z[A_W-1:0];
		end
	end

	assign a_q   = Q_W'(a);
	assign mag_q = f.dx_neg ? DEG180_Q16 - a_q : a_q;
	assign mag   = mag_q[FRAC_W +: ANGLE_W];

	always_comb begin
		priority if (!f.dx_neg && f.dy_neg) begin
			full_q = DEG360_Q16 - a_q;
		end else if (f.dx_neg && f.dy_neg) begin
			full_q = DEG180_Q16 + a_q;
		end else if (f.dx_neg) begin
			full_q = DEG180_Q16 - a_q;
		end else begin
			full_q = a_q;
		end
	end

	always_comb begin
		unique case (angle_mode)
			MODE_ATAN2: begin
				priority if (f.dx_zero && f.dy_zero) begin
					angle = ANG_0;
				end else if (f.dx_zero) begin
					angle = f.dy_neg ? ANG_NEG90 : ANG_90;
				end else if (f.dy_zero) begin
					angle = f.dx_neg ? ANG_180 : ANG_0;
				end else begin
					angle = f.dy_neg ? -mag : mag;
				end
			end
			MODE_SCREEN: begin
				priority if (f.dx_zero) begin
					angle = f.dy_neg ? ANG_270 : ANG_90;
				end else if (f.dy_zero) begin
					angle = f.dx_neg ? ANG_180 : ANG_0;
				end else begin
					angle = full_q[FRAC_W +: ANGLE_W];
				end
			end
			default: begin
				angle = ANG_0;
			end
		endcase
	end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the point pair angle unit: directed and random point pairs.
`timescale 1ns / 1ps

module tb_top;
	import ppad_pkg::*;

	localparam int CORDIC_ROUNDS = 16;
	localparam int PIPE_LATENCY  = CORDIC_ROUNDS + 2;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_BATCH  = 250;

	// atan(2^-i) in degrees with 16 fractional bits, rounded to nearest
	localparam longint DEG_ATAN_Q16 [CORDIC_ROUNDS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	typedef struct packed {
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
	} point_pair_t;

	// Holds the mode shadow, predicts each accepted request and checks results in order.
	class angle_scoreboard;
		logic                       mode;
		logic signed [ANGLE_W-1:0]  expected_angles [$];
		int                         mismatches;

		function new();
			mode       = MODE_ATAN2;
			mismatches = 0;
		endfunction

		// first-quadrant angle of (ax, ay), both positive, degrees in Q16
		function longint quadrant_one_angle(longint ax, longint ay);
			longint x;
			longint y;
			longint z;
			longint xs;
			longint ys;
			x = ax * 256;
			y = ay * 256;
			z = 0;
			for (int i = 0; i < CORDIC_ROUNDS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + DEG_ATAN_Q16[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - DEG_ATAN_Q16[i];
				end
			end
			if (z < 1)
				z = 1;
			if (z > (longint'(90) << 16) - 1)
				z = (longint'(90) << 16) - 1;
			return z;
		endfunction

		function logic signed [ANGLE_W-1:0] angle_of_pair(point_pair_t p);
			longint dx;
			longint dy;
			longint a;
			longint mag;
			longint q;
			longint res;
			dx = longint'(p.sx) - longint'(p.fx);
			dy = longint'(p.sy) - longint'(p.fy);
			if (mode == MODE_ATAN2) begin
				if (dx == 0 && dy == 0)
					res = 0;
				else if (dx == 0)
					res = (dy > 0) ? 90 : -90;
				else if (dy == 0)
					res = (dx > 0) ? 0 : 180;
				else begin
					a   = quadrant_one_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
					mag = (dx > 0) ? a : (longint'(180) << 16) - a;
					mag = mag >>> 16;
					res = (dy < 0) ? -mag : mag;
				end
			end else begin
				if (dx == 0)
					res = (dy < 0) ? 270 : 90;
				else if (dy == 0)
					res = (dx > 0) ? 0 : 180;
				else begin
					a = quadrant_one_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
					if (dx > 0 && dy < 0)
						q = (longint'(360) << 16) - a;
					else if (dx < 0 && dy < 0)
						q = (longint'(180) << 16) + a;
					else if (dx < 0)
						q = (longint'(180) << 16) - a;
					else
						q = a;
					res = q >>> 16;
				end
			end
			return res[ANGLE_W-1:0];
		endfunction

		function void note_request(point_pair_t p);
			expected_angles.push_back(angle_of_pair(p));
		endfunction

		function void check_result(logic signed [ANGLE_W-1:0] actual);
			logic signed [ANGLE_W-1:0] want;
			if (expected_angles.size() == 0) begin
				$error("angle_degrees: no request outstanding, actual %0d", actual);
				mismatches++;
			end else begin
				want = expected_angles.pop_front();
				if (actual !== want) begin
					$error("angle_degrees mismatch: expected %0d, actual %0d", want, actual);
					mismatches++;
				end
			end
		endfunction

		function int outstanding();
			return expected_angles.size();
		endfunction
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_wdata = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [15:0] first_x   = '0;
	logic signed [15:0] first_y   = '0;
	logic signed [15:0] second_x  = '0;
	logic signed [15:0] second_y  = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [9:0]  angle_degrees;

	angle_scoreboard board;
	point_pair_t     request_fifo [$];
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	bit              long_hold_req = 1'b0;
	int              hold_left     = 0;
	int              cycle_count   = 0;

	point_pair_angle_degrees_unit #(
		.CORDIC_STAGES(CORDIC_ROUNDS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.angle_degrees(angle_degrees)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abandon the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[point_pair_angle_degrees_unit] ERROR");
			$finish;
		end
	end

	// Output side: stall at random, or hold off for a long stretch once asked, so that the
	// whole chain fills and the input stall is exercised while requests keep being offered.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (long_hold_req) begin
			long_hold_req <= 1'b0;
			hold_left     <= LONG_HOLD;
			out_stall     <= 1'b1;
		end else begin
			out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every result taken at an edge where it is valid and not stalled.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(angle_degrees);
	end

	function automatic logic signed [15:0] extreme_coord();
		case ($urandom_range(4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'sh0001;
		endcase
	endfunction

	// Mostly geometric corner cases with random content, the rest plain noise.
	function automatic point_pair_t random_pair();
		point_pair_t p;
		int          kind;
		p.fx = 16'($urandom);
		p.fy = 16'($urandom);
		p.sx = 16'($urandom);
		p.sy = 16'($urandom);
		kind = $urandom_range(99);
		if (kind < 35) begin
			// leave fully random
		end else if (kind < 50) begin
			p.sx = p.fx + 16'($urandom_range(16)) - 16'd8;
			p.sy = p.fy + 16'($urandom_range(16)) - 16'd8;
		end else if (kind < 62) begin
			p.sx = p.fx + 16'($urandom_range(2048)) - 16'd1024;
			p.sy = p.fy + 16'($urandom_range(2048)) - 16'd1024;
		end else if (kind < 71) begin
			p.sx = p.fx;
		end else if (kind < 80) begin
			p.sy = p.fy;
		end else if (kind < 85) begin
			p.sx = p.fx;
			p.sy = p.fy;
		end else begin
			p.fx = extreme_coord();
			p.fy = extreme_coord();
			p.sx = extreme_coord();
			p.sy = extreme_coord();
		end
		return p;
	endfunction

	function automatic point_pair_t make_pair(int fx, int fy, int sx, int sy);
		point_pair_t p;
		p.fx = 16'(fx);
		p.fy = 16'(fy);
		p.sx = 16'(sx);
		p.sy = 16'(sy);
		return p;
	endfunction

	// Corner cases: equal points, vertical, horizontal, full-range diagonals, clamp limits.
	task automatic load_directed();
		request_fifo.push_back(make_pair(0, 0, 0, 0));
		request_fifo.push_back(make_pair(-32768, -32768, -32768, -32768));
		request_fifo.push_back(make_pair(5, 5, 5, 100));
		request_fifo.push_back(make_pair(5, 5, 5, -100));
		request_fifo.push_back(make_pair(0, 0, 300, 0));
		request_fifo.push_back(make_pair(0, 0, -300, 0));
		request_fifo.push_back(make_pair(-32768, -32768, 32767, 32767));
		request_fifo.push_back(make_pair(32767, 32767, -32768, -32768));
		request_fifo.push_back(make_pair(-32768, 32767, 32767, -32768));
		request_fifo.push_back(make_pair(32767, -32768, -32768, 32767));
		// nearly horizontal and nearly vertical: angle hits the clamp limits
		request_fifo.push_back(make_pair(-32768, 0, 32767, 1));
		request_fifo.push_back(make_pair(0, -32768, 1, 32767));
	endtask

	task automatic write_mode(logic m);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.mode = m;
	endtask

	// Offer every queued request; hold the payload while stalled, idle at random between.
	task automatic send_requests();
		point_pair_t cur;
		bit          offering;
		offering = 1'b0;
		cur      = '0;
		while (request_fifo.size() > 0 || offering) begin
			@(posedge clk);
			if (offering && !in_stall) begin
				board.note_request(cur);
				offering = 1'b0;
			end
			if (!offering) begin
				if (request_fifo.size() > 0 &&
				    !(send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)) begin
					cur      = request_fifo.pop_front();
					offering = 1'b1;
					first_x  <= cur.fx;
					first_y  <= cur.fy;
					second_x <= cur.sx;
					second_y <= cur.sy;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	endtask

	task automatic drain();
		while (board.outstanding() > 0)
			@(posedge clk);
	endtask

	initial begin
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners in both modes, no idling.
		write_mode(MODE_ATAN2);
		load_directed();
		send_requests();
		drain();
		write_mode(MODE_SCREEN);
		load_directed();
		send_requests();
		drain();

		// Random part: three idling regimes, each in both modes.
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int half = 0; half < 2; half++) begin
				write_mode((half == regime % 2) ? MODE_ATAN2 : MODE_SCREEN);
				for (int n = 0; n < RANDOM_BATCH; n++)
					request_fifo.push_back(random_pair());
				// fill the chain once against a long output hold
				if (regime == 0 && half == 0) begin
					@(posedge clk);
					long_hold_req <= 1'b1;
				end
				send_requests();
				drain();
			end
		end

		// Let any stray result surface before the verdict.
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("[point_pair_angle_degrees_unit] OK");
		else
			$display("[point_pair_angle_degrees_unit] ERROR");
		$finish;
	end

endmodule

// ----- point_pair_angle_degrees_unit.f -----
hdl/ppad_pkg.sv
hdl/ppad_front.sv
hdl/ppad_cell.sv
hdl/ppad_finish.sv
hdl/point_pair_angle_degrees_unit.sv
dv/tb_top.sv
